FILE: rtl/core/order_batch_matcher_assert.svh
// Assertion macros for the order batch matcher.
`ifndef ORDER_BATCH_MATCHER_ASSERT_SVH
`define ORDER_BATCH_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
`define OBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OBM_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define OBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OBM_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: rtl/core/obm_pkg.sv
package obm_pkg;

    localparam int MAX_ORDERS = 16;
    localparam int IDX_W      = $clog2(MAX_ORDERS);
    localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
    localparam int PRICE_W    = 40;
    localparam int AMOUNT_W   = 40;
    localparam int PROD_W     = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 32;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 88;

    localparam logic CFG_PRODUCT = 1'b0;
    localparam logic CFG_TIME    = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CHECK,
        ST_MATCH,
        ST_FLUSH
    } obm_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_empty;
        logic flush;
        logic clear;
    } obm_cmd_t;

    typedef struct packed {
        logic side_empty;
        logic scan_done;
        logic pend_valid;
        logic out_free;
    } obm_status_t;

endpackage

FILE: rtl/core/obm_ctrl.sv
module obm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  obm_pkg::obm_status_t status,
    output obm_pkg::obm_cmd_t    cmd
);
    import obm_pkg::*;

    obm_state_t state_reg;
    obm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.side_empty)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_empty = 1'b1;
                        cmd.clear      = 1'b1;
                        state_next     = ST_LOAD;
                    end
                end
                else
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!status.pend_valid || status.out_free)
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/core/obm_datapath.sv
module obm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [obm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_side,
    input  logic [obm_pkg::PROD_W-1:0]    in_product,
    input  logic [obm_pkg::TIME_W-1:0]    in_time,
    input  logic [obm_pkg::PRICE_W-1:0]   in_price,
    input  logic [obm_pkg::AMOUNT_W-1:0]  in_amount,
    input  logic                          in_own,
    input  obm_pkg::obm_cmd_t             cmd,
    output obm_pkg::obm_status_t          status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [obm_pkg::PRICE_W-1:0]   out_price,
    output logic [obm_pkg::AMOUNT_W-1:0]  out_amount,
    output logic                          out_kind,
    output logic                          out_own,
    output logic                          out_none,
    output logic                          out_overflow,
    output logic                          out_last
);
    import obm_pkg::*;

    logic [PROD_W-1:0]   want_prod_reg;
    logic [TIME_W-1:0]   want_time_reg;

    logic [PRICE_W-1:0]  ask_p_reg [MAX_ORDERS];
    logic [AMOUNT_W-1:0] ask_a_reg [MAX_ORDERS];
    logic                ask_o_reg [MAX_ORDERS];
    logic [PRICE_W-1:0]  bid_p_reg [MAX_ORDERS];
    logic [AMOUNT_W-1:0] bid_a_reg [MAX_ORDERS];
    logic                bid_o_reg [MAX_ORDERS];
    logic [CNT_W-1:0]    ask_cnt_reg;
    logic [CNT_W-1:0]    bid_cnt_reg;
    logic                dropped_reg;

    logic [CNT_W-1:0]    a_reg;
    logic [CNT_W-1:0]    b_reg;

    logic                pend_valid_reg;
    logic [PRICE_W-1:0]  pend_price_reg;
    logic [AMOUNT_W-1:0] pend_amount_reg;
    logic                pend_kind_reg;
    logic                pend_own_reg;

    logic                out_valid_reg;
    logic [PRICE_W-1:0]  out_price_reg;
    logic [AMOUNT_W-1:0] out_amount_reg;
    logic                out_kind_reg;
    logic                out_own_reg;
    logic                out_none_reg;
    logic                out_over_reg;
    logic                out_last_reg;

    logic                keep;
    logic                ask_ins;
    logic                bid_ins;
    logic [MAX_ORDERS-1:0] ask_go;
    logic [MAX_ORDERS-1:0] bid_go;

    logic [PRICE_W-1:0]  cur_ap;
    logic [AMOUNT_W-1:0] cur_aa;
    logic                cur_ao;
    logic [PRICE_W-1:0]  cur_bp;
    logic [AMOUNT_W-1:0] cur_ba;
    logic                cur_bo;
    logic                scan_done;
    logic                bids_done;
    logic                out_free;
    logic                trade;
    logic                full_fill;
    logic [AMOUNT_W-1:0] trade_amount;

    assign keep    = (in_product == want_prod_reg) && (in_time == want_time_reg);
    assign ask_ins = cmd.load && keep && !in_side && (ask_cnt_reg < CNT_W'(MAX_ORDERS));
    assign bid_ins = cmd.load && keep && in_side && (bid_cnt_reg < CNT_W'(MAX_ORDERS));

    always_comb
    begin
        for (int i = 0; i < MAX_ORDERS; i++)
        begin
            ask_go[i] = (CNT_W'(i) >= ask_cnt_reg) || (in_price < ask_p_reg[i]);
            bid_go[i] = (CNT_W'(i) >= bid_cnt_reg) || (in_price > bid_p_reg[i]);
        end
    end

    assign cur_ap    = ask_p_reg[a_reg[IDX_W-1:0]];
    assign cur_aa    = ask_a_reg[a_reg[IDX_W-1:0]];
    assign cur_ao    = ask_o_reg[a_reg[IDX_W-1:0]];
    assign cur_bp    = bid_p_reg[b_reg[IDX_W-1:0]];
    assign cur_ba    = bid_a_reg[b_reg[IDX_W-1:0]];
    assign cur_bo    = bid_o_reg[b_reg[IDX_W-1:0]];
    assign scan_done = a_reg >= ask_cnt_reg;
    assign bids_done = b_reg >= bid_cnt_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign full_fill    = cur_ba >= cur_aa;
    assign trade        = cmd.step && !bids_done && (cur_bp >= cur_ap)
                          && (full_fill || (cur_ba != '0));
    assign trade_amount = full_fill ? cur_aa : cur_ba;

    assign status.side_empty = (ask_cnt_reg == '0) || (bid_cnt_reg == '0);
    assign status.scan_done  = scan_done;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_prod_reg <= '0;
            want_time_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRODUCT: want_prod_reg <= cfg_data[PROD_W-1:0];
                CFG_TIME:    want_time_reg <= cfg_data[TIME_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ORDERS; i++)
        begin
            if (ask_ins)
            begin
                if (ask_go[i] && (i == 0 || !ask_go[(i > 0) ? i - 1 : 0]))
                begin
                    ask_p_reg[i] <= in_price;
                    ask_a_reg[i] <= in_amount;
                    ask_o_reg[i] <= in_own;
                end
                else if (i > 0 && ask_go[(i > 0) ? i - 1 : 0])
                begin
                    ask_p_reg[i] <= ask_p_reg[(i > 0) ? i - 1 : 0];
                    ask_a_reg[i] <= ask_a_reg[(i > 0) ? i - 1 : 0];
                    ask_o_reg[i] <= ask_o_reg[(i > 0) ? i - 1 : 0];
                end
            end
            if (bid_ins)
            begin
                if (bid_go[i] && (i == 0 || !bid_go[(i > 0) ? i - 1 : 0]))
                begin
                    bid_p_reg[i] <= in_price;
                    bid_a_reg[i] <= in_amount;
                    bid_o_reg[i] <= in_own;
                end
                else if (i > 0 && bid_go[(i > 0) ? i - 1 : 0])
                begin
                    bid_p_reg[i] <= bid_p_reg[(i > 0) ? i - 1 : 0];
                    bid_a_reg[i] <= bid_a_reg[(i > 0) ? i - 1 : 0];
                    bid_o_reg[i] <= bid_o_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
        if (trade)
        begin
            if (full_fill)
            begin
                bid_a_reg[b_reg[IDX_W-1:0]] <= cur_ba - cur_aa;
            end
            else
            begin
                ask_a_reg[a_reg[IDX_W-1:0]] <= cur_aa - cur_ba;
                bid_a_reg[b_reg[IDX_W-1:0]] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ask_cnt_reg    <= '0;
            bid_cnt_reg    <= '0;
            dropped_reg    <= 1'b0;
            a_reg          <= '0;
            b_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ask_ins)
            begin
                ask_cnt_reg <= ask_cnt_reg + 1'b1;
            end
            if (bid_ins)
            begin
                bid_cnt_reg <= bid_cnt_reg + 1'b1;
            end
            if (cmd.load && keep && !ask_ins && !bid_ins)
            begin
                dropped_reg <= 1'b1;
            end
            if (cmd.step)
            begin
                if (bids_done || (trade && full_fill))
                begin
                    a_reg <= a_reg + 1'b1;
                    b_reg <= '0;
                end
                else
                begin
                    b_reg <= b_reg + 1'b1;
                end
            end
            if (trade)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (cmd.emit_empty || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.clear)
            begin
                ask_cnt_reg    <= '0;
                bid_cnt_reg    <= '0;
                dropped_reg    <= 1'b0;
                a_reg          <= '0;
                b_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (trade)
        begin
            pend_price_reg  <= cur_ap;
            pend_amount_reg <= trade_amount;
            pend_kind_reg   <= cur_bo && !cur_ao;
            pend_own_reg    <= cur_bo || cur_ao;
        end
        if ((trade && pend_valid_reg) || cmd.flush)
        begin
            out_price_reg  <= pend_price_reg;
            out_amount_reg <= pend_amount_reg;
            out_kind_reg   <= pend_kind_reg;
            out_own_reg    <= pend_own_reg;
            out_none_reg   <= 1'b0;
            out_over_reg   <= dropped_reg;
            out_last_reg   <= cmd.flush;
        end
        else if (cmd.emit_empty)
        begin
            out_price_reg  <= '0;
            out_amount_reg <= '0;
            out_kind_reg   <= 1'b0;
            out_own_reg    <= 1'b0;
            out_none_reg   <= 1'b1;
            out_over_reg   <= dropped_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_price    = out_price_reg;
    assign out_amount   = out_amount_reg;
    assign out_kind     = out_kind_reg;
    assign out_own      = out_own_reg;
    assign out_none     = out_none_reg;
    assign out_overflow = out_over_reg;
    assign out_last     = out_last_reg;

endmodule

FILE: rtl/core/order_batch_matcher.sv
// Batch order matcher. Orders stream in one per cycle and are filtered on the
// configured product and time codes, then sorted into 16-entry ask and bid
// books as they arrive. The order flagged with tlast closes the batch: the
// block stops taking orders, then scans asks against bids one ask/bid pair per
// cycle while the output does not stall, and takes no new order until the
// scan ends and its last result is registered. Every result leaves through
// one output register; a batch with an empty side gives one no_trade result.
`include "order_batch_matcher_assert.svh"

module order_batch_matcher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [obm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // product_code, time_code, order_price, order_amount, own_order, zero pad
    input  logic [obm_pkg::IN_DATA_W-1:0]     s_tdata,
    // order_side
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sale_price, sale_amount, own_sale, no_trade, overflow, zero pad
    output logic [obm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // sale_kind
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import obm_pkg::*;

    obm_cmd_t            cmd;
    obm_status_t         status;
    logic [PRICE_W-1:0]  sale_price;
    logic [AMOUNT_W-1:0] sale_amount;
    logic                own_sale;
    logic                no_trade;
    logic                overflow;

    obm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    obm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_side      (s_tuser),
        .in_product   (s_tdata[7:0]),
        .in_time      (s_tdata[39:8]),
        .in_price     (s_tdata[79:40]),
        .in_amount    (s_tdata[119:80]),
        .in_own       (s_tdata[120]),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_price    (sale_price),
        .out_amount   (sale_amount),
        .out_kind     (m_tuser),
        .out_own      (own_sale),
        .out_none     (no_trade),
        .out_overflow (overflow),
        .out_last     (m_tlast)
    );

    assign m_tdata = {5'b0, overflow, no_trade, own_sale, sale_amount, sale_price};

    `OBM_ASSERT_IMPLY(a_none_last, clk, rst_n, m_tvalid && no_trade, m_tlast)
    `OBM_ASSERT_IMPLY(a_none_zero, clk, rst_n, m_tvalid && no_trade, sale_amount == '0)
    `OBM_ASSERT_NEVER(a_no_load_busy, clk, rst_n, s_tready && status.pend_valid)

endmodule
